// ===== sv/sorted_max_priority_queue_defines.svh =====
// Assertion macros used by the sorted max-priority queue sequencer.
`ifndef SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_MAX_PRIORITY_QUEUE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define SMPQ_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Condition that must hold in the same cycle as its trigger.
`define SMPQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define SMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/smpq_pkg.sv =====
// Types and constants shared by the sorted max-priority queue modules.
package smpq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VAL_W    = 32;
   localparam int OCC_W    = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_REMOVED  = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic                    we;
      logic [IDX_W-1:0]        waddr;
      logic signed [VAL_W-1:0] wdata;
      logic [IDX_W-1:0]        raddr;
   } mem_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] out_value;
      status_type              status;
      logic [OCC_W-1:0]        occupancy;
   } res_type;

endpackage

// ===== sv/smpq_store.sv =====
// Sorted entry store: one write port and one registered read port.
module smpq_store
   import smpq_pkg::*;
(
   input  logic                    clock,
   input  mem_req_type             mem_req,
   output logic signed [VAL_W-1:0] rdata
);

   logic signed [VAL_W-1:0] mem_ff [CAPACITY];
   logic signed [VAL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= mem_ff[mem_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/smpq_ctrl.sv =====
// Sequencer with the shared compare unit that walks the store one entry a cycle.
`include "sorted_max_priority_queue_defines.svh"
module smpq_ctrl
   import smpq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic signed [VAL_W-1:0] req_value,
   output mem_req_type             mem_req,
   input  logic signed [VAL_W-1:0] rdata,
   output logic                    res_valid,
   output res_type                 res,
   input  logic                    out_free
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_INS_CMP   = 6'b000010,
      ST_INS_PUT   = 6'b000100,
      ST_REM_HEAD  = 6'b001000,
      ST_REM_SHIFT = 6'b010000,
      ST_FINISH    = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [VAL_W-1:0] res_value_ff, res_value_in;
   status_type              res_status_ff, res_status_in;
   logic                    shift_up;
   logic [CNT_W-1:0]        count_next;

   // Shared compare unit: the stored entry moves back when it is not above the new value.
   assign shift_up = (rdata <= value_ff);

   always_comb begin
      unique case (res_status_ff)
         STATUS_INSERTED: count_next = count_ff + 1'b1;
         STATUS_REMOVED:  count_next = count_ff - 1'b1;
         default:         count_next = count_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      value_in      = value_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = idx_ff;
      mem_req.wdata = value_ff;
      mem_req.raddr = idx_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               value_in     = req_value;
               res_value_in = '0;
               if (req_cmd == CMD_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_FINISH;
                  end else if (count_ff == '0) begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = '0;
                     mem_req.wdata = req_value;
                     res_status_in = STATUS_INSERTED;
                     state_in      = ST_FINISH;
                  end else begin
                     mem_req.raddr = IDX_W'(count_ff - 1'b1);
                     idx_in        = IDX_W'(count_ff - 1'b1);
                     state_in      = ST_INS_CMP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_FINISH;
                  end else begin
                     mem_req.raddr = '0;
                     idx_in        = '0;
                     state_in      = ST_REM_HEAD;
                  end
               end
            end
         end
         ST_INS_CMP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff + 1'b1;
            if (shift_up) begin
               mem_req.wdata = rdata;
               if (idx_ff == '0) begin
                  state_in = ST_INS_PUT;
               end else begin
                  idx_in        = idx_ff - 1'b1;
                  mem_req.raddr = idx_ff - 1'b1;
               end
            end else begin
               mem_req.wdata = value_ff;
               res_status_in = STATUS_INSERTED;
               state_in      = ST_FINISH;
            end
         end
         ST_INS_PUT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = value_ff;
            res_status_in = STATUS_INSERTED;
            state_in      = ST_FINISH;
         end
         ST_REM_HEAD: begin
            res_value_in  = rdata;
            res_status_in = STATUS_REMOVED;
            if (count_ff == CNT_W'(1)) begin
               state_in = ST_FINISH;
            end else begin
               idx_in        = IDX_W'(1);
               mem_req.raddr = IDX_W'(1);
               state_in      = ST_REM_SHIFT;
            end
         end
         ST_REM_SHIFT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff - 1'b1;
            mem_req.wdata = rdata;
            if (CNT_W'(idx_ff) + 1'b1 == count_ff) begin
               state_in = ST_FINISH;
            end else begin
               idx_in        = idx_ff + 1'b1;
               mem_req.raddr = idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            res_valid = 1'b1;
            if (out_free) begin
               count_in = count_next;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.out_value = res_value_ff;
   assign res.status    = res_status_ff;
   assign res.occupancy = OCC_W'(count_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
   end

   `SMPQ_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `SMPQ_ASSERT_IMPLY(a_write_in_range, mem_req.we, CNT_W'(mem_req.waddr) <= count_ff, "write beyond fill")
   `SMPQ_ASSERT_NEXT(a_empty_remove, state_ff == ST_IDLE && req_valid && req_cmd == CMD_REMOVE && count_ff == '0, state_ff == ST_FINISH && res_status_ff == STATUS_EMPTY, "empty remove not reported")
   `SMPQ_ASSERT_NEXT(a_count_hold, state_ff != ST_FINISH, $stable(count_ff), "count moved outside finish")

endmodule

// ===== sv/sorted_max_priority_queue.sv =====
// Top level of the sorted max-priority queue with its result register.
//
// The queue keeps up to CAPACITY signed 32-bit values in descending order.
// Each request transaction carries a command (insert or remove largest) and a
// value; each one produces exactly one response transaction with the removed
// value, a status (inserted, removed, empty, full) and the occupancy after it.
// Equal values leave last in, first out. An insert into a full queue and a
// remove from an empty queue change nothing and report their status.
// The sequencer moves one entry per cycle through the store (one write port,
// one registered read port) and its one comparator: an insert walks from the
// last entry toward the head, moving entries back until its place is found;
// a remove reads the head and shifts the rest forward. A full or empty case
// and an insert into an empty queue need no walk. A new request is accepted
// only in the idle state, after the previous response has been handed over.
// The response sits in an output register, so a stalled receiver does not
// stop the next request being processed; only its final hand-over waits.
// Reset is synchronous and active high: the queue empties and no response is
// valid. Store contents are not cleared, since entries beyond the fill count
// are never read.
module sorted_max_priority_queue
   import smpq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_out_value,
   output logic [1:0]              rsp_status,
   output logic [OCC_W-1:0]        rsp_occupancy
);

   mem_req_type             mem_req;
   logic signed [VAL_W-1:0] rdata;
   logic                    res_valid;
   res_type                 res;
   logic                    out_free;
   logic                    rsp_valid_ff, rsp_valid_in;
   res_type                 rsp_ff, rsp_in;

   smpq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   smpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .req_value (req_value),
      .mem_req   (mem_req),
      .rdata     (rdata),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free)
   );

   // The register may take a new response when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_ff.out_value;
   assign rsp_status    = rsp_ff.status;
   assign rsp_occupancy = rsp_ff.occupancy;

endmodule
